@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the segment LCD driver.
// Needs no other file; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CHK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(name, clk, rst_n, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);

`endif

@@ src/slcd_pkg.sv @@
// Types, op codes and glyph/decimal helpers for the segment LCD driver.
// No dependencies.
package slcd_pkg;

	localparam int NumComs  = 4;
	localparam int NumLines = 5;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SET_HEX   = 3'd1,
		OP_DEC_NUM   = 3'd2,
		OP_HEX_NUM   = 3'd3,
		OP_CLR_DIGIT = 3'd4,
		OP_CLR_ALL   = 3'd5,
		OP_SYMBOL    = 3'd6,
		OP_REFRESH   = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        digit_pos;
		logic [7:0]  value;
		logic [2:0]  symbol_index;
		logic        symbol_on;
		logic [15:0] frame_count;
	} item_t;

	typedef struct packed {
		logic [4:0] seg_level;
		logic [4:0] seg_enable;
		logic [3:0] com_level;
		logic [3:0] com_enable;
		logic       busy_res;
	} result_t;

	// Seven-segment glyph, segment a in bit 0.
	function automatic logic [6:0] glyph(input logic [3:0] d);
		logic [6:0] g;
		unique case (d)
			4'h0: g = 7'h3F;
			4'h1: g = 7'h06;
			4'h2: g = 7'h5B;
			4'h3: g = 7'h4F;
			4'h4: g = 7'h66;
			4'h5: g = 7'h6D;
			4'h6: g = 7'h7D;
			4'h7: g = 7'h07;
			4'h8: g = 7'h7F;
			4'h9: g = 7'h6F;
			4'hA: g = 7'h77;
			4'hB: g = 7'h7C;
			4'hC: g = 7'h39;
			4'hD: g = 7'h5E;
			4'hE: g = 7'h79;
			default: g = 7'h71;
		endcase
		return g;
	endfunction

	// Quotient by ten for an 8-bit value: reciprocal multiply, exact here.
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return p[15:11];
	endfunction

endpackage

@@ src/segment_lcd_multiplex_driver.sv @@
// Top level of the multiplexed two-digit segment LCD driver.
// Depends on slcd_pkg and assert_macros.svh.
//
// Usage:
//   item channel (item_valid/item_ready/item): one op per item - tick,
//   digit and symbol edits, clears, or start of a refresh of N frames.
//   result channel (result_valid/result_ready/result): one result per
//   item, the segment and common drive levels and enables after that item.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes phase_ticks, the
//   ticks per drive phase (zero acts as one); always ready.
// Latency: the result of an item is presented the cycle after it is
//   accepted. Throughput: one item per cycle unless a waiting result stalls
//   the item side; the decode, the tick counter compare and the pattern
//   select sit between the state registers and the result register.
// Stall: the result register holds while result_ready is low, and a new
//   item is taken in the same cycle the waiting result is taken.
// Reset: arst_n clears the digit and symbol stores, the captured frame
//   patterns, the phase/tick/frame counters and the result valid flag;
//   phase_ticks returns to one. The block is idle with all drives off.
// A refresh frame has eight phases; phases 2k and 2k+1 drive common k.
module segment_lcd_multiplex_driver (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  slcd_pkg::item_t        item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output slcd_pkg::result_t      result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [15:0]            cfg_data
);

	`include "assert_macros.svh"

	logic [15:0] phase_ticks_q;
	logic [6:0]  digit_first_q, digit_second_q;
	logic [5:0]  symbol_q;
	logic [4:0]  pattern_q [slcd_pkg::NumComs];
	logic [2:0]  phase_q;
	logic [15:0] tick_q;
	logic [15:0] frames_q;
	logic        result_valid_q;
	slcd_pkg::result_t result_q;

	logic [6:0]  digit_first_d, digit_second_d;
	logic [5:0]  symbol_d;
	logic [2:0]  phase_d;
	logic [15:0] tick_d;
	logic [15:0] frames_d;
	logic        capture;
	logic        accept;
	logic [16:0] tick_inc;
	logic [15:0] limit;
	logic [4:0]  tens;
	logic [3:0]  tens_mod, ones;
	logic [7:0]  tens_x10;
	logic [4:0]  pat_cap [slcd_pkg::NumComs];
	logic [4:0]  pat_sel;
	logic [1:0]  com;
	logic [3:0]  com_bit;
	slcd_pkg::result_t result_d;

	assign accept       = item_valid && item_ready;
	assign item_ready   = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// Split a decimal value into tens mod ten and ones
	always_comb begin
		tens     = slcd_pkg::div10(item.value);
		tens_x10 = 8'(tens) * 8'd10;
		ones     = 4'(item.value - tens_x10);
		if (tens >= 5'd20) begin
			tens_mod = 4'(tens - 5'd20);
		end else if (tens >= 5'd10) begin
			tens_mod = 4'(tens - 5'd10);
		end else begin
			tens_mod = tens[3:0];
		end
	end

	// Decode the op and advance the refresh timing
	always_comb begin
		digit_first_d  = digit_first_q;
		digit_second_d = digit_second_q;
		symbol_d       = symbol_q;
		phase_d        = phase_q;
		tick_d         = tick_q;
		frames_d       = frames_q;
		capture        = 1'b0;
		limit          = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
		tick_inc       = 17'(tick_q) + 17'd1;
		unique case (slcd_pkg::op_t'(item.op))
			slcd_pkg::OP_TICK: begin
				if (frames_q != '0) begin
					if (tick_inc >= 17'(limit)) begin
						tick_d  = '0;
						phase_d = phase_q + 3'd1;
						if (phase_q == 3'd7) begin
							frames_d = frames_q - 16'd1;
						end
					end else begin
						tick_d = tick_inc[15:0];
					end
				end
			end
			slcd_pkg::OP_SET_HEX: begin
				if (item.digit_pos) begin
					digit_first_d = slcd_pkg::glyph(item.value[3:0]);
				end else begin
					digit_second_d = slcd_pkg::glyph(item.value[3:0]);
				end
			end
			slcd_pkg::OP_DEC_NUM: begin
				digit_second_d = slcd_pkg::glyph(tens_mod);
				digit_first_d  = slcd_pkg::glyph(ones);
			end
			slcd_pkg::OP_HEX_NUM: begin
				digit_second_d = slcd_pkg::glyph(item.value[7:4]);
				digit_first_d  = slcd_pkg::glyph(item.value[3:0]);
			end
			slcd_pkg::OP_CLR_DIGIT: begin
				if (item.digit_pos) begin
					digit_first_d = '0;
				end else begin
					digit_second_d = '0;
				end
			end
			slcd_pkg::OP_CLR_ALL: begin
				digit_first_d  = '0;
				digit_second_d = '0;
				symbol_d       = '0;
			end
			slcd_pkg::OP_SYMBOL: begin
				if (item.symbol_index < 3'd6) begin
					symbol_d[item.symbol_index] = item.symbol_on;
				end
			end
			slcd_pkg::OP_REFRESH: begin
				capture  = 1'b1;
				frames_d = item.frame_count;
				phase_d  = '0;
				tick_d   = '0;
			end
			default: begin
			end
		endcase
	end

	// Map the current stores onto the lit lines of each common
	always_comb begin
		pat_cap[0] = {digit_second_q[4], symbol_q[0], digit_second_q[3],
			digit_first_q[4], digit_first_q[3]};
		pat_cap[1] = {digit_second_q[6], symbol_q[1], digit_second_q[2],
			digit_first_q[6], digit_first_q[2]};
		pat_cap[2] = {digit_second_q[1], digit_second_q[5], digit_first_q[5],
			digit_first_q[0], digit_first_q[1]};
		pat_cap[3] = {digit_second_q[0], symbol_q[5], symbol_q[4],
			symbol_q[3], symbol_q[2]};
	end

	// Form the drive levels from the state after this item
	always_comb begin
		com     = phase_d[2:1];
		com_bit = 4'b0001 << com;
		pat_sel = capture ? pat_cap[com] : pattern_q[com];
		if (frames_d != '0) begin
			result_d.seg_level  = phase_d[0] ? 5'b0 : pat_sel;
			result_d.seg_enable = pat_sel;
			result_d.com_level  = phase_d[0] ? com_bit : 4'b0;
			result_d.com_enable = com_bit;
			result_d.busy_res   = 1'b1;
		end else begin
			result_d = '0;
		end
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// Update stores and counters on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_first_q  <= '0;
			digit_second_q <= '0;
			symbol_q       <= '0;
			phase_q        <= '0;
			tick_q         <= '0;
			frames_q       <= '0;
			for (int i = 0; i < slcd_pkg::NumComs; i++) begin
				pattern_q[i] <= '0;
			end
		end else if (accept) begin
			digit_first_q  <= digit_first_d;
			digit_second_q <= digit_second_d;
			symbol_q       <= symbol_d;
			phase_q        <= phase_d;
			tick_q         <= tick_d;
			frames_q       <= frames_d;
			if (capture) begin
				for (int i = 0; i < slcd_pkg::NumComs; i++) begin
					pattern_q[i] <= pat_cap[i];
				end
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	`ASSERT_NEXT(a_result_after_item, clk, arst_n, accept, result_valid_q,
		"accepted item produced no result")
	`ASSERT_CHK(a_idle_counters_clear, clk, arst_n,
		(frames_q != '0) || (phase_q == '0 && tick_q == '0),
		"phase or tick counter left over while idle")
	`ASSERT_CHK(a_com_onehot_busy, clk, arst_n,
		result_valid_q |-> (result_q.busy_res ? $onehot(result_q.com_enable)
		: (result_q == '0)), "common enables disagree with busy flag")
	`ASSERT_CHK(a_level_within_enable, clk, arst_n,
		result_valid_q |-> ((result_q.seg_level & ~result_q.seg_enable) == '0),
		"segment line driven high while not enabled")

endmodule

@@ tb/segment_lcd_multiplex_driver_tb.sv @@
`timescale 1ns / 100ps
// Testbench for segment_lcd_multiplex_driver: directed and random items checked
// against an in-bench prediction of the drive state. Depends on slcd_pkg and the RTL.
module segment_lcd_multiplex_driver_tb;

	localparam int RUN_LIMIT = 300000;

	// Glyph per hex digit, segment a in bit 0, digit 0 in the low bits
	localparam logic [111:0] SEG_FONT = {
		7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	typedef enum int {
		PACE_SEND_GAPS,
		PACE_RECV_GAPS,
		PACE_FULL
	} pace_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	slcd_pkg::item_t   item_data = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	slcd_pkg::result_t result_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [15:0]       cfg_data = '0;

	pace_t       pace = PACE_SEND_GAPS;
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	int          applied_items = 0;
	bit          last_ignored = 1'b0;

	// Predicted block state
	logic [15:0] phase_len = 16'd1;
	logic [6:0]  digit_first = '0;
	logic [6:0]  digit_second = '0;
	logic [5:0]  symbol_bits = '0;
	logic [4:0]  line_pattern [4] = '{default: '0};
	logic [2:0]  phase_idx = '0;
	logic [16:0] tick_count = '0;
	logic [15:0] frames_left = '0;

	slcd_pkg::result_t expected_drive [$];

	segment_lcd_multiplex_driver DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAIL segment_lcd_multiplex_driver");
			$finish;
		end
	end

	// Stall the result side according to the current pace
	always @(posedge clk) begin
		case (pace)
			PACE_SEND_GAPS: result_ready <= ($urandom_range(99) >= 57);
			PACE_RECV_GAPS: result_ready <= ($urandom_range(99) >= 25);
			default:        result_ready <= 1'b1;
		endcase
	end

	function automatic logic [6:0] font(input int d);
		return SEG_FONT[d*7 +: 7];
	endfunction

	// Latch the lit lines of each common from the digit and symbol stores
	function automatic void capture_lines();
		line_pattern[0] = {digit_second[4], symbol_bits[0], digit_second[3],
			digit_first[4], digit_first[3]};
		line_pattern[1] = {digit_second[6], symbol_bits[1], digit_second[2],
			digit_first[6], digit_first[2]};
		line_pattern[2] = {digit_second[1], digit_second[5], digit_first[5],
			digit_first[0], digit_first[1]};
		line_pattern[3] = {digit_second[0], symbol_bits[5:2]};
	endfunction

	// Apply one item to the predicted state and return the drive after it
	function automatic slcd_pkg::result_t lcd_predict(input slcd_pkg::item_t it);
		slcd_pkg::result_t r;
		logic [1:0]        com;
		logic [4:0]        pat;
		logic [16:0]       lim;
		r = '0;
		last_ignored = 1'b0;
		case (slcd_pkg::op_t'(it.op))
			slcd_pkg::OP_TICK: begin
				if (frames_left == 0) begin
					last_ignored = 1'b1;
				end else begin
					lim = (phase_len == 0) ? 17'd1 : {1'b0, phase_len};
					tick_count = tick_count + 17'd1;
					if (tick_count >= lim) begin
						tick_count = '0;
						phase_idx = phase_idx + 3'd1;
						if (phase_idx == 0)
							frames_left = frames_left - 16'd1;
					end
				end
			end
			slcd_pkg::OP_SET_HEX: begin
				if (it.digit_pos)
					digit_first = font(int'(it.value[3:0]));
				else
					digit_second = font(int'(it.value[3:0]));
			end
			slcd_pkg::OP_DEC_NUM: begin
				digit_second = font((int'(it.value) / 10) % 10);
				digit_first = font(int'(it.value) % 10);
			end
			slcd_pkg::OP_HEX_NUM: begin
				digit_second = font(int'(it.value[7:4]));
				digit_first = font(int'(it.value[3:0]));
			end
			slcd_pkg::OP_CLR_DIGIT: begin
				if (it.digit_pos)
					digit_first = '0;
				else
					digit_second = '0;
			end
			slcd_pkg::OP_CLR_ALL: begin
				digit_first = '0;
				digit_second = '0;
				symbol_bits = '0;
			end
			slcd_pkg::OP_SYMBOL: begin
				if (it.symbol_index < 3'd6)
					symbol_bits[it.symbol_index] = it.symbol_on;
				else
					last_ignored = 1'b1;
			end
			slcd_pkg::OP_REFRESH: begin
				capture_lines();
				frames_left = it.frame_count;
				phase_idx = '0;
				tick_count = '0;
			end
		endcase
		if (frames_left != 0) begin
			com = phase_idx[2:1];
			pat = line_pattern[com];
			r.seg_enable = pat;
			r.seg_level = phase_idx[0] ? 5'd0 : pat;
			r.com_enable = 4'b0001 << com;
			r.com_level = phase_idx[0] ? (4'b0001 << com) : 4'd0;
			r.busy_res = 1'b1;
		end
		return r;
	endfunction

	function automatic slcd_pkg::item_t make_item(input slcd_pkg::op_t op, input logic pos,
		input logic [7:0] val, input logic [2:0] sym, input logic on,
		input logic [15:0] frames);
		slcd_pkg::item_t it;
		it.op = op;
		it.digit_pos = pos;
		it.value = val;
		it.symbol_index = sym;
		it.symbol_on = on;
		it.frame_count = frames;
		return it;
	endfunction

	// Random content in every field, op given
	function automatic slcd_pkg::item_t random_item(input slcd_pkg::op_t op);
		return make_item(op, 1'($urandom_range(1)), 8'($urandom_range(255)),
			3'($urandom_range(7)), 1'($urandom_range(1)), 16'($urandom_range(65535)));
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h (cycle %0d)", field, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic check_drive(input slcd_pkg::result_t got, input slcd_pkg::result_t want);
		if (got.seg_level !== want.seg_level)
			report_mismatch("seg_level", int'(got.seg_level), int'(want.seg_level));
		if (got.seg_enable !== want.seg_enable)
			report_mismatch("seg_enable", int'(got.seg_enable), int'(want.seg_enable));
		if (got.com_level !== want.com_level)
			report_mismatch("com_level", int'(got.com_level), int'(want.com_level));
		if (got.com_enable !== want.com_enable)
			report_mismatch("com_enable", int'(got.com_enable), int'(want.com_enable));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_drive.size() == 0) begin
				report_mismatch("unexpected result", int'(result_data), 0);
			end else begin
				check_drive(result_data, expected_drive.pop_front());
			end
		end
	end

	// Offer one item, idle first as the pace asks, predict on acceptance
	task automatic send_item(input slcd_pkg::item_t it);
		int gap_pct;
		gap_pct = (pace == PACE_SEND_GAPS) ? 25 : (pace == PACE_RECV_GAPS) ? 57 : 0;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_data <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		expected_drive.push_back(lcd_predict(it));
		if (!last_ignored)
			applied_items++;
	endtask

	// Hold off until every predicted result has been taken
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_phase_len(input logic [15:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		phase_len = v;
	endtask

	task automatic test_idle_ticks();
		send_item(make_item(slcd_pkg::OP_TICK, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_TICK, 1'b1, 8'hFF, 3'd7, 1'b1, 16'hFFFF));
	endtask

	task automatic test_display_edits();
		send_item(make_item(slcd_pkg::OP_SET_HEX, 1'b1, 8'hFF, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_SET_HEX, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_DEC_NUM, 1'b0, 8'd255, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_DEC_NUM, 1'b1, 8'd99, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_HEX_NUM, 1'b0, 8'hA5, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_SYMBOL, 1'b0, 8'h00, 3'd0, 1'b1, 16'h0000));
		send_item(make_item(slcd_pkg::OP_SYMBOL, 1'b0, 8'h00, 3'd5, 1'b1, 16'h0000));
		// out-of-range symbol indexes are dropped
		send_item(make_item(slcd_pkg::OP_SYMBOL, 1'b0, 8'h00, 3'd6, 1'b1, 16'h0000));
		send_item(make_item(slcd_pkg::OP_SYMBOL, 1'b0, 8'h00, 3'd7, 1'b1, 16'h0000));
		send_item(make_item(slcd_pkg::OP_SYMBOL, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
	endtask

	task automatic test_refresh_sequencing();
		// one full frame at one tick per phase, running out to idle
		send_item(make_item(slcd_pkg::OP_REFRESH, 1'b0, 8'h00, 3'd0, 1'b0, 16'd1));
		repeat (8)
			send_item(make_item(slcd_pkg::OP_TICK, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_CLR_DIGIT, 1'b1, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_CLR_DIGIT, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_REFRESH, 1'b0, 8'h00, 3'd0, 1'b0, 16'hFFFF));
		// edit while busy: shows only after the restart below
		send_item(make_item(slcd_pkg::OP_SET_HEX, 1'b1, 8'h08, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_TICK, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
		send_item(make_item(slcd_pkg::OP_REFRESH, 1'b0, 8'h00, 3'd0, 1'b0, 16'd2));
		send_item(make_item(slcd_pkg::OP_REFRESH, 1'b0, 8'h00, 3'd0, 1'b0, 16'd0));
		send_item(make_item(slcd_pkg::OP_CLR_ALL, 1'b0, 8'h00, 3'd0, 1'b0, 16'h0000));
	endtask

	// Up to three edits, a refresh, then a run of mostly ticks that can finish a short refresh
	task automatic run_display_sequence();
		int              pick;
		int              span;
		int              eff;
		int              frames;
		slcd_pkg::item_t it;
		repeat ($urandom_range(3))
			send_item(random_item(slcd_pkg::op_t'($urandom_range(6, 1))));
		it = random_item(slcd_pkg::OP_REFRESH);
		pick = $urandom_range(99);
		if (pick < 70)
			it.frame_count = 16'($urandom_range(3, 1));
		else if (pick < 80)
			it.frame_count = '0;
		send_item(it);
		eff = (phase_len == 0) ? 1 : int'(phase_len);
		frames = int'(it.frame_count);
		span = 64;
		if (frames <= 3 && eff <= 8)
			span = 8 * eff * frames + 3;
		if (span > 64)
			span = 64;
		repeat ($urandom_range(span, span / 2 + 1)) begin
			if ($urandom_range(99) < 10)
				send_item(random_item(slcd_pkg::op_t'($urandom_range(6, 1))));
			else
				send_item(random_item(slcd_pkg::OP_TICK));
		end
	endtask

	task automatic test_random_traffic(input logic [15:0] len_setting, input int target);
		int start;
		bit paused;
		wait_drained();
		write_phase_len(len_setting);
		start = applied_items;
		paused = 1'b0;
		while (applied_items - start < target) begin
			if ($urandom_range(99) < 65)
				run_display_sequence();
			else
				send_item(random_item(slcd_pkg::op_t'($urandom_range(7))));
			// let the whole pipeline empty once mid-stream
			if (!paused && applied_items - start >= target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pace = PACE_SEND_GAPS;
		test_idle_ticks();
		test_display_edits();
		test_refresh_sequencing();

		test_random_traffic(16'd1, 275);
		test_random_traffic(16'd3, 275);
		pace = PACE_RECV_GAPS;
		test_random_traffic(16'd0, 275);
		test_random_traffic(16'd2, 275);
		pace = PACE_FULL;
		test_random_traffic(16'hFFFF, 275);
		test_random_traffic(16'($urandom_range(6, 1)), 275);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS segment_lcd_multiplex_driver");
		else
			$display("FAIL segment_lcd_multiplex_driver");
		$finish;
	end

endmodule
